>>> rtl/core/vapn_pkg.sv
package vapn_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int SUM_W      = 64;
    localparam int PROD_W     = DATA_W + SUM_W;
    localparam int SQRT_STEPS = SUM_W / 2;
    localparam int DIV_STEPS  = FRAC_BITS + 1;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_AMP   = 2'd1;
    localparam logic [1:0] MODE_PHASE = 2'd2;

    localparam logic [DATA_W-1:0] AMP_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_ZERO,
        KIND_AMP,
        KIND_PHASE
    } kind_t;

    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
        logic [DATA_W-1:0] w;
        logic [DATA_W-1:0] wsc;
        logic [SUM_W-1:0]  x;
        logic [SUM_W-1:0]  r;
        logic [SUM_W-1:0]  bit_m;
        logic [SUM_W-1:0]  rem_re;
        logic [SUM_W-1:0]  rem_im;
        logic [SUM_W-1:0]  dvs;
        logic [DATA_W-1:0] q_re;
        logic [DATA_W-1:0] q_im;
    } ctx_t;

    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
        mag32 = v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

>>> rtl/core/visibility_amp_phase_normalizer_unit.sv
// Amplitude/phase normalizer for Q16.16 visibilities. While the output is not
// stalled, one word is taken per cycle and one result word leaves per cycle.
// Each word passes the front multiply stages, the 32 square-root cells, the
// divider setup stage, the 17 divider cells and the output register. A stalled
// output holds the whole chain. Write mode only while no words are in flight.
module visibility_amp_phase_normalizer_unit
    import vapn_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [3*DATA_W-1:0] s_tdata,   // re_in, im_in, weight_in
    input  logic [1:0]          s_tuser,   // sample_flag, row_flag
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [3*DATA_W-1:0] m_tdata    // re_out, im_out, weight_out
);

    logic [1:0]          mode_reg;
    logic                en;
    logic                active;
    ctx_t                in_ctx;
    ctx_t                sq_ctx [SQRT_STEPS+1];
    ctx_t                prep_reg, prep_next;
    ctx_t                dv_ctx [DIV_STEPS+1];
    ctx_t                fin;
    logic                m_tvalid_reg;
    logic [3*DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [DATA_W-1:0]   amp, re_o, im_o, w_o;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NONE;
        end else if (cfg_we) begin
            mode_reg <= cfg_wdata;
        end
    end

    always_comb begin
        in_ctx       = '0;
        in_ctx.valid = s_tvalid;
        in_ctx.re    = s_tdata[DATA_W-1:0];
        in_ctx.im    = s_tdata[2*DATA_W-1:DATA_W];
        in_ctx.w     = s_tdata[3*DATA_W-1:2*DATA_W];
        active       = (mode_reg == MODE_AMP || mode_reg == MODE_PHASE) && !s_tuser[1];
        if (!active) begin
            in_ctx.kind = KIND_PASS;
        end else if (s_tuser[0]) begin
            in_ctx.kind = KIND_ZERO;
        end else if (in_ctx.re == '0 && in_ctx.im == '0) begin
            in_ctx.kind = KIND_PASS;
        end else if (mode_reg == MODE_AMP) begin
            in_ctx.kind = KIND_AMP;
        end else begin
            in_ctx.kind = KIND_PHASE;
        end
    end

    vapn_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_ctx  (in_ctx),
        .out_ctx (sq_ctx[0])
    );

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
        vapn_sqrt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_ctx  (sq_ctx[i]),
            .out_ctx (sq_ctx[i+1])
        );
    end

    // divider setup: numerator |x| << F plus half the amplitude for rounding
    always_comb begin
        prep_next        = sq_ctx[SQRT_STEPS];
        prep_next.rem_re = (SUM_W'(mag32(sq_ctx[SQRT_STEPS].re)) << FRAC_BITS)
                           + (sq_ctx[SQRT_STEPS].r >> 1);
        prep_next.rem_im = (SUM_W'(mag32(sq_ctx[SQRT_STEPS].im)) << FRAC_BITS)
                           + (sq_ctx[SQRT_STEPS].r >> 1);
        prep_next.dvs    = sq_ctx[SQRT_STEPS].r << FRAC_BITS;
        prep_next.q_re   = '0;
        prep_next.q_im   = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_reg.valid <= 1'b0;
        end else if (en) begin
            prep_reg <= prep_next;
        end
    end

    assign dv_ctx[0] = prep_reg;

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        vapn_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_ctx  (dv_ctx[j]),
            .out_ctx (dv_ctx[j+1])
        );
    end

    assign fin = dv_ctx[DIV_STEPS];

    always_comb begin
        amp  = (|fin.r[SUM_W-1:DATA_W-1]) ? AMP_MAX : fin.r[DATA_W-1:0];
        re_o = fin.re;
        im_o = fin.im;
        w_o  = fin.w;
        case (fin.kind)
            KIND_ZERO: begin
                re_o = '0;
                im_o = '0;
                w_o  = '0;
            end
            KIND_AMP: begin
                re_o = amp;
                im_o = '0;
            end
            KIND_PHASE: begin
                re_o = fin.re[DATA_W-1] ? (~fin.q_re + 1'b1) : fin.q_re;
                im_o = fin.im[DATA_W-1] ? (~fin.q_im + 1'b1) : fin.q_im;
                w_o  = fin.wsc;
            end
            default: begin
            end
        endcase
        m_tdata_next = {w_o, im_o, re_o};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= fin.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

>>> rtl/core/vapn_front.sv
module vapn_front
    import vapn_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  ctx_t in_ctx,
    output ctx_t out_ctx
);

    ctx_t              s1_reg, s2_reg, s3_reg, s4_reg;
    ctx_t              s2_next, s4_next;
    logic [SUM_W-1:0]  sqre_reg, sqim_reg;
    logic [SUM_W-1:0]  plo_reg, phi_reg;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] prod_sh;
    logic [DATA_W-1:0] wsc_next;

    // weight * sum is split into two 32x32 halves, added a stage later
    always_comb begin
        prod     = {{DATA_W{1'b0}}, plo_reg} + {phi_reg, {DATA_W{1'b0}}};
        prod_sh  = prod >> (2 * FRAC_BITS);
        wsc_next = (|prod_sh[PROD_W-1:DATA_W]) ? '1 : prod_sh[DATA_W-1:0];
    end

    always_comb begin
        s2_next       = s1_reg;
        s2_next.x     = sqre_reg + sqim_reg;
        s4_next       = s3_reg;
        s4_next.wsc   = wsc_next;
        s4_next.r     = '0;
        s4_next.bit_m = SUM_W'(1) << (SUM_W - 2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
            s2_reg.valid <= 1'b0;
            s3_reg.valid <= 1'b0;
            s4_reg.valid <= 1'b0;
        end else if (en) begin
            s1_reg   <= in_ctx;
            sqre_reg <= SUM_W'(mag32(in_ctx.re)) * SUM_W'(mag32(in_ctx.re));
            sqim_reg <= SUM_W'(mag32(in_ctx.im)) * SUM_W'(mag32(in_ctx.im));

            s2_reg   <= s2_next;

            s3_reg  <= s2_reg;
            plo_reg <= SUM_W'(s2_reg.w) * SUM_W'(s2_reg.x[DATA_W-1:0]);
            phi_reg <= SUM_W'(s2_reg.w) * SUM_W'(s2_reg.x[SUM_W-1:DATA_W]);

            s4_reg   <= s4_next;
        end
    end

    assign out_ctx = s4_reg;

endmodule

>>> rtl/core/vapn_sqrt_cell.sv
module vapn_sqrt_cell
    import vapn_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  ctx_t in_ctx,
    output ctx_t out_ctx
);

    ctx_t             ctx_reg, ctx_next;
    logic [SUM_W-1:0] trial;

    // one root bit per cell; the trial bit walks down by two each cell
    always_comb begin
        ctx_next = in_ctx;
        trial    = in_ctx.r + in_ctx.bit_m;
        if (in_ctx.x >= trial) begin
            ctx_next.x = in_ctx.x - trial;
            ctx_next.r = (in_ctx.r >> 1) + in_ctx.bit_m;
        end else begin
            ctx_next.r = in_ctx.r >> 1;
        end
        ctx_next.bit_m = in_ctx.bit_m >> 2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg.valid <= 1'b0;
        end else if (en) begin
            ctx_reg <= ctx_next;
        end
    end

    assign out_ctx = ctx_reg;

endmodule

>>> rtl/core/vapn_div_cell.sv
module vapn_div_cell
    import vapn_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  ctx_t in_ctx,
    output ctx_t out_ctx
);

    ctx_t ctx_reg, ctx_next;

    // one quotient bit for both parts per cell, shared shifted divisor
    always_comb begin
        ctx_next = in_ctx;
        if (in_ctx.rem_re >= in_ctx.dvs) begin
            ctx_next.rem_re = in_ctx.rem_re - in_ctx.dvs;
            ctx_next.q_re   = {in_ctx.q_re[DATA_W-2:0], 1'b1};
        end else begin
            ctx_next.q_re   = {in_ctx.q_re[DATA_W-2:0], 1'b0};
        end
        if (in_ctx.rem_im >= in_ctx.dvs) begin
            ctx_next.rem_im = in_ctx.rem_im - in_ctx.dvs;
            ctx_next.q_im   = {in_ctx.q_im[DATA_W-2:0], 1'b1};
        end else begin
            ctx_next.q_im   = {in_ctx.q_im[DATA_W-2:0], 1'b0};
        end
        ctx_next.dvs = in_ctx.dvs >> 1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg.valid <= 1'b0;
        end else if (en) begin
            ctx_reg <= ctx_next;
        end
    end

    assign out_ctx = ctx_reg;

endmodule

>>> dv/tb.sv
module tb;
    import vapn_pkg::*;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic [31:0] w;
    } vis_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic [1:0]          cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [3*DATA_W-1:0] s_tdata;   // re_in, im_in, weight_in
    logic [1:0]          s_tuser;   // sample_flag, row_flag
    logic                m_tvalid;
    logic                m_tready;
    logic [3*DATA_W-1:0] m_tdata;   // re_out, im_out, weight_out

    logic [1:0] cur_mode;
    vis_t       expected_vis[$];
    int         err_count;
    longint     cycle_count;
    bit         quiet_sender;
    bit         quiet_receiver;
    bit         finished;

    visibility_amp_phase_normalizer_unit dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] unit_part(input logic [31:0] v, input logic [63:0] amp);
        logic [63:0] m;
        logic [63:0] q;
        m = v[31] ? {32'd0, -v} : {32'd0, v};
        q = ((m << FRAC_BITS) + (amp >> 1)) / amp;
        return v[31] ? -q[31:0] : q[31:0];
    endfunction

    function automatic vis_t normalize(input vis_t v, input logic sflag, input logic rflag);
        vis_t        o;
        logic [63:0] mre;
        logic [63:0] mim;
        logic [63:0] sum;
        logic [63:0] amp;
        logic [95:0] prod;
        o = v;
        if ((cur_mode != MODE_AMP && cur_mode != MODE_PHASE) || rflag) return o;
        if (sflag) begin
            o.re = 0; o.im = 0; o.w = 0;
            return o;
        end
        mre = v.re[31] ? {32'd0, -v.re} : {32'd0, v.re};
        mim = v.im[31] ? {32'd0, -v.im} : {32'd0, v.im};
        sum = mre * mre + mim * mim;
        if (sum == 0) return o;
        amp = int_sqrt(sum);
        if (cur_mode == MODE_PHASE) begin
            o.re = unit_part(v.re, amp);
            o.im = unit_part(v.im, amp);
            prod = ({64'd0, v.w} * {32'd0, sum}) >> (2 * FRAC_BITS);
            o.w = (prod > 96'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
        end else begin
            o.re = (amp > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : amp[31:0];
            o.im = 0;
        end
        return o;
    endfunction

    // receiver: random stalls, checks each word against the oldest expectation
    always @(negedge aclk) begin
        m_tready <= quiet_receiver ? 1'b1 : ($urandom_range(99) >= 22);
    end

    always @(posedge aclk) begin
        vis_t e;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_vis.size() == 0) begin
                $error("unexpected word %h", m_tdata);
                err_count++;
            end else begin
                e = expected_vis.pop_front();
                if (m_tdata[31:0] !== e.re) begin
                    $error("re_out exp %h got %h", e.re, m_tdata[31:0]);
                    err_count++;
                end
                if (m_tdata[63:32] !== e.im) begin
                    $error("im_out exp %h got %h", e.im, m_tdata[63:32]);
                    err_count++;
                end
                if (m_tdata[95:64] !== e.w) begin
                    $error("weight_out exp %h got %h", e.w, m_tdata[95:64]);
                    err_count++;
                end
            end
        end
    end

    initial begin
        wait (cycle_count >= 64'd400000);
        if (!finished) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // valid stays high after an accept; drain() or a waiting next call drops it
    task automatic send_word(input vis_t v, input logic sflag, input logic rflag);
        while (!quiet_sender && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {v.w, v.im, v.re};
        s_tuser  <= {rflag, sflag};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_vis.push_back(normalize(v, sflag, rflag));
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_vis.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        cur_mode  = m;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [31:0] rand_data();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(2 * 65536) - 65536;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(8) - 4;
            default: return $urandom_range(2000000) - 1000000;
        endcase
    endfunction

    task automatic send_random(input int n);
        vis_t v;
        for (int i = 0; i < n; i++) begin
            v.re = rand_data();
            v.im = rand_data();
            v.w  = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom;
            send_word(v, $urandom_range(9) == 0, $urandom_range(9) == 0);
        end
    endtask

    task automatic test_directed();
        vis_t v;
        logic [31:0] vals[6] = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
                                  32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0003};
        for (int m = 0; m < 4; m++) begin
            write_mode(m[1:0]);
            for (int i = 0; i < 6; i++) begin
                v.re = vals[i];
                v.im = vals[(i + 1) % 6];
                v.w  = (i % 2) ? 32'hFFFF_FFFF : 32'h0001_0000;
                send_word(v, 1'b0, 1'b0);
            end
            v.re = 0; v.im = 0; v.w = 32'h1234_5678;
            send_word(v, 1'b0, 1'b0);
            v.re = 32'h8000_0000; v.im = 32'h8000_0000;
            send_word(v, 1'b1, 1'b0);
            send_word(v, 1'b1, 1'b1);
            send_word(v, 1'b0, 1'b1);
        end
    endtask

    task automatic test_random_modes();
        logic [1:0] order[5] = '{MODE_PHASE, MODE_AMP, MODE_NONE, MODE_PHASE, MODE_AMP};
        for (int p = 0; p < 5; p++) begin
            write_mode(order[p]);
            send_random(300);
        end
    endtask

    task automatic test_no_stall();
        write_mode(MODE_PHASE);
        quiet_sender   = 1'b1;
        quiet_receiver = 1'b1;
        send_random(200);
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
    endtask

    task automatic test_pause_refill();
        write_mode(MODE_AMP);
        send_random(50);
        drain();    // sender holds off until all results are back
        send_random(50);
    endtask

    initial begin
        err_count = 0;
        cycle_count = 0;
        finished = 1'b0;
        quiet_sender = 1'b0;
        quiet_receiver = 1'b0;
        cur_mode = MODE_NONE;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 2'd0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_modes();
        test_no_stall();
        test_pause_refill();
        drain();
        finished = 1'b1;
        if (err_count == 0 && expected_vis.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
